[hdl/tlch_pkg.sv]
package tlch_pkg;

  typedef struct packed {
    logic        kind;
    logic [7:0]  word_addr;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  served_from;
  } out_item_t;

  localparam logic       KIND_WRITE = 1'b1;
  localparam logic [1:0] SRC_L1     = 2'd0;
  localparam logic [1:0] SRC_L2     = 2'd1;
  localparam logic [1:0] SRC_RAM    = 2'd2;

endpackage

[hdl/tlch_queue.sv]
// two-entry queue between the accepting front and the cache engine
module tlch_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tlch_pkg::in_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output tlch_pkg::in_item_t head_item
);

  tlch_pkg::in_item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head_item = mem_r[rp_r];

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && !not_empty))
    else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");

endmodule

[hdl/tlch_engine.sv]
// cache engine: one transaction at a time, one memory word per cycle
module tlch_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  tlch_pkg::in_item_t  item,
  output logic                item_pop,
  output logic                res_valid,
  output tlch_pkg::out_item_t res,
  input  logic                res_taken
);

  typedef enum logic [10:0] {
    S_CLR   = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_LOOK  = 11'b00000000100,
    S_WB    = 11'b00000001000,
    S_L2F   = 11'b00000010000,
    S_L1F   = 11'b00000100000,
    S_WL1   = 11'b00001000000,
    S_WLK   = 11'b00010000000,
    S_WBW   = 11'b00100000000,
    S_L2FW  = 11'b01000000000,
    S_CPY   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] l1_mem [16];
  logic [4:0]  l1_tag_r [8];
  logic [7:0]  l1_val_r, l1_ord_r;
  logic [31:0] l2_mem [64];
  logic [2:0]  l2_tag_r [16];
  logic [15:0] l2_val_r, l2_dirty_r, l2_ord_r;
  logic [31:0] ram [256];

  tlch_pkg::in_item_t cur_r;
  logic [7:0]  clr_r;
  logic [2:0]  k_r;
  logic [2:0]  kd;
  logic        w1_r, w2_r;
  logic [31:0] data_r;
  logic [1:0]  src_r;
  logic        res_valid_r;
  logic [31:0] l2_rd_r;
  logic [31:0] ram_rd_r;

  // address fields
  logic [1:0] s1;
  logic [4:0] t1;
  logic [2:0] s2, t2;
  assign s1 = cur_r.word_addr[2:1];
  assign t1 = cur_r.word_addr[7:3];
  assign s2 = cur_r.word_addr[4:2];
  assign t2 = cur_r.word_addr[7:5];

  // word index of the registered read data, one behind the counter
  assign kd = k_r - 3'd1;

  // tag compare
  logic h1_0, h1_1, h2_0, h2_1;
  assign h1_0 = l1_val_r[{s1, 1'b0}] && l1_tag_r[{s1, 1'b0}] == t1;
  assign h1_1 = l1_val_r[{s1, 1'b1}] && l1_tag_r[{s1, 1'b1}] == t1;
  assign h2_0 = l2_val_r[{s2, 1'b0}] && l2_tag_r[{s2, 1'b0}] == t2;
  assign h2_1 = l2_val_r[{s2, 1'b1}] && l2_tag_r[{s2, 1'b1}] == t2;

  // victim choice
  logic v1, v2;
  assign v1 = !l1_val_r[{s1, 1'b0}] ? 1'b0 : !l1_val_r[{s1, 1'b1}] ? 1'b1 :
              !l1_ord_r[{s1, 1'b0}] ? 1'b0 : !l1_ord_r[{s1, 1'b1}] ? 1'b1 : 1'b0;
  assign v2 = !l2_val_r[{s2, 1'b0}] ? 1'b0 : !l2_val_r[{s2, 1'b1}] ? 1'b1 :
              !l2_ord_r[{s2, 1'b0}] ? 1'b0 : !l2_ord_r[{s2, 1'b1}] ? 1'b1 : 1'b0;
  logic v2_dirty;
  assign v2_dirty = l2_val_r[{s2, v2}] && l2_dirty_r[{s2, v2}];

  logic wr;
  assign wr = (cur_r.kind == tlch_pkg::KIND_WRITE);

  assign item_pop  = (state_r == S_IDLE) && item_valid && !res_valid_r;
  assign res_valid = res_valid_r;
  assign res.read_data   = data_r;
  assign res.served_from = src_r;

  // read addresses for the moving word; l2 and ram data are read through registers
  logic [31:0] l1_word;
  logic [5:0]  l2_idx;
  logic [7:0]  ram_idx;
  always_comb begin
    if (state_r == S_L1F) l2_idx = {s2, w2_r, cur_r.word_addr[1], k_r[0]};
    else l2_idx = {s2, w2_r, k_r[1:0]};
    ram_idx = {t2, s2, k_r[1:0]};
    l1_word = l1_mem[{s1, w1_r, k_r[0]}];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (clr_r == 8'hff) state_nxt = S_IDLE;
      S_IDLE: if (item_pop) state_nxt = S_LOOK;
      S_LOOK: begin
        if (h1_0 || h1_1) state_nxt = wr ? S_WL1 : S_IDLE;
        else if (h2_0 || h2_1) state_nxt = S_L1F;
        else state_nxt = v2_dirty ? S_WB : S_L2F;
      end
      S_WB:   if (k_r == 3'd4) state_nxt = S_L2F;
      S_L2F:  if (k_r == 3'd4) state_nxt = S_L1F;
      S_L1F:  if (k_r == 3'd2) state_nxt = wr ? S_WL1 : S_IDLE;
      S_WL1:  state_nxt = S_WLK;
      S_WLK:  state_nxt = (h2_0 || h2_1) ? S_CPY : (v2_dirty ? S_WBW : S_L2FW);
      S_WBW:  if (k_r == 3'd4) state_nxt = S_L2FW;
      S_L2FW: if (k_r == 3'd4) state_nxt = S_CPY;
      S_CPY:  if (k_r[0]) state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= 8'd0;
      k_r         <= 3'd0;
      res_valid_r <= 1'b0;
      l1_val_r    <= '0;
      l1_ord_r    <= '0;
      l2_val_r    <= '0;
      l2_dirty_r  <= '0;
      l2_ord_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (res_valid_r && res_taken) res_valid_r <= 1'b0;
      if (state_nxt != state_r) k_r <= 3'd0;
      else k_r <= k_r + 3'd1;
      unique case (state_r)
        S_CLR: clr_r <= clr_r + 8'd1;
        S_LOOK: begin
          if (h1_0 || h1_1) begin
            data_r <= l1_mem[{s1, h1_1, cur_r.word_addr[0]}];
            src_r  <= tlch_pkg::SRC_L1;
            if (!wr) res_valid_r <= 1'b1;
          end else if (h2_0 || h2_1) begin
            w2_r   <= h2_1;
            data_r <= l2_mem[{s2, h2_1, cur_r.word_addr[1:0]}];
            src_r  <= tlch_pkg::SRC_L2;
          end else begin
            w2_r  <= v2;
            src_r <= tlch_pkg::SRC_RAM;
          end
          w1_r <= (h1_0 || h1_1) ? h1_1 : v1;
        end
        S_L2F, S_L2FW: begin
          if (k_r == 3'd4) begin
            l2_val_r[{s2, w2_r}]   <= 1'b1;
            l2_dirty_r[{s2, w2_r}] <= 1'b0;
            l2_ord_r[{s2, w2_r}]   <= 1'b0;
            l2_ord_r[{s2, ~w2_r}]  <= ~l2_ord_r[{s2, ~w2_r}];
            l2_tag_r[{s2, w2_r}]   <= t2;
          end
          if (state_r == S_L2F && k_r != 3'd0 && kd[1:0] == cur_r.word_addr[1:0])
            data_r <= ram_rd_r;
        end
        S_L1F: begin
          if (k_r == 3'd2) begin
            l1_val_r[{s1, w1_r}]  <= 1'b1;
            l1_ord_r[{s1, w1_r}]  <= 1'b0;
            l1_ord_r[{s1, ~w1_r}] <= ~l1_ord_r[{s1, ~w1_r}];
            l1_tag_r[{s1, w1_r}]  <= t1;
            if (!wr) res_valid_r <= 1'b1;
          end
        end
        S_WLK: w2_r <= (h2_0 || h2_1) ? h2_1 : v2;
        S_CPY: if (k_r[0]) begin
          l2_dirty_r[{s2, w2_r}] <= 1'b1;
          res_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload and memories
  always_ff @(posedge clk) begin
    if (item_pop) cur_r <= item;
    l2_rd_r  <= l2_mem[l2_idx];
    ram_rd_r <= ram[ram_idx];
    if (state_r == S_CLR) ram[clr_r] <= 32'd0;
    if ((state_r == S_WB || state_r == S_WBW) && k_r != 3'd0)
      ram[{l2_tag_r[{s2, w2_r}], s2, kd[1:0]}] <= l2_rd_r;
    if ((state_r == S_L2F || state_r == S_L2FW) && k_r != 3'd0)
      l2_mem[{s2, w2_r, kd[1:0]}] <= ram_rd_r;
    if (state_r == S_L1F && k_r != 3'd0) l1_mem[{s1, w1_r, kd[0]}] <= l2_rd_r;
    if (state_r == S_WL1) l1_mem[{s1, w1_r, cur_r.word_addr[0]}] <= cur_r.write_data;
    if (state_r == S_CPY) l2_mem[{s2, w2_r, cur_r.word_addr[1], k_r[0]}] <= l1_word;
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(item_pop && state_r != S_IDLE))
    else $error("pop while busy");
  a_copy_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == S_CPY && !l2_val_r[{s2, w2_r}]))
    else $error("copy into invalid l2 line");
  a_no_res_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_valid_r && state_r == S_CLR))
    else $error("result during clear");

endmodule

[hdl/two_level_cache_hierarchy_core.sv]
// two-level cache (l1 4x2 ways of 2 words, l2 8x2 ways of 4 words) over 256-word ram
// in_* channel takes read or write transactions (kind, word_addr, write_data);
// out_* channel returns read_data (old word on a write) and served_from level.
// a transaction is taken when valid is high and stall is low on that channel.
// the front queues up to two transactions; the engine runs one at a time.
// an l1 read hit answers from the lookup; an l2 hit adds an l1 fill, a ram miss an
// l2 fill before that, and a dirty victim a write-back first; a write then adds
// an l1 update and an l2 copy, with an l2 fill (and write-back) when l2 misses.
// one memory word moves per cycle through registered reads, which sets the miss
// and write times; the engine takes the next transaction the cycle after its
// result is taken. after reset the ram is cleared; the queue still takes two
// transactions then, after which in_stall stays high until the clear ends.
// a stalled result holds; the engine waits for it before starting the next,
// and in_stall rises once the queue holds two transactions.
module two_level_cache_hierarchy_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tlch_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tlch_pkg::out_item_t out_data
);

  logic q_full, q_ne, pop;
  tlch_pkg::in_item_t head;

  assign in_stall = q_full;

  tlch_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(in_valid && !q_full), .push_item(in_data), .full(q_full),
    .pop(pop), .not_empty(q_ne), .head_item(head)
  );

  tlch_engine u_engine (
    .clk(clk), .rst_n(rst_n),
    .item_valid(q_ne), .item(head), .item_pop(pop),
    .res_valid(out_valid), .res(out_data), .res_taken(!out_stall)
  );

endmodule

[tb/tb_two_level_cache_hierarchy_checker.sv]
module tb_two_level_cache_hierarchy_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  tlch_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  tlch_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of both cache levels and the main store
  logic [31:0] l1_word [4][2][2];
  logic [4:0]  l1_tag  [4][2];
  logic        l1_vld  [4][2];
  logic        l1_ord  [4][2];
  logic [31:0] l2_word [8][2][4];
  logic [2:0]  l2_tag  [8][2];
  logic        l2_vld  [8][2];
  logic        l2_dty  [8][2];
  logic        l2_ord  [8][2];
  logic [31:0] ram [256];

  tlch_pkg::out_item_t expected_reads [$];

  function automatic int pick_victim(logic v0, logic v1, logic o0, logic o1);
    if (!v0) return 0;
    if (!v1) return 1;
    if (!o0) return 0;
    if (!o1) return 1;
    return 0;
  endfunction

  function automatic int l1_lookup(logic [1:0] s, logic [4:0] t);
    for (int w = 0; w < 2; w++)
      if (l1_vld[s][w] && l1_tag[s][w] == t) return w;
    return -1;
  endfunction

  function automatic int l2_lookup(logic [2:0] s, logic [2:0] t);
    for (int w = 0; w < 2; w++)
      if (l2_vld[s][w] && l2_tag[s][w] == t) return w;
    return -1;
  endfunction

  // load a block into l2, writing a dirty victim back first
  function automatic int l2_load(logic [2:0] s, logic [2:0] t);
    int w;
    w = pick_victim(l2_vld[s][0], l2_vld[s][1], l2_ord[s][0], l2_ord[s][1]);
    if (l2_vld[s][w] && l2_dty[s][w])
      for (int k = 0; k < 4; k++) ram[{l2_tag[s][w], s, k[1:0]}] = l2_word[s][w][k];
    l2_vld[s][w] = 1'b1;
    l2_dty[s][w] = 1'b0;
    l2_ord[s][w] = 1'b0;
    l2_tag[s][w] = t;
    l2_ord[s][w ^ 1] = ~l2_ord[s][w ^ 1];
    for (int k = 0; k < 4; k++) l2_word[s][w][k] = ram[{t, s, k[1:0]}];
    return w;
  endfunction

  function automatic tlch_pkg::out_item_t access_cache(tlch_pkg::in_item_t tr);
    logic [7:0] a;
    logic [1:0] s1;
    logic [4:0] t1;
    logic [2:0] s2, t2;
    logic       hf;
    int w1, w2;
    tlch_pkg::out_item_t r;
    a = tr.word_addr;
    s1 = a[2:1]; t1 = a[7:3]; s2 = a[4:2]; t2 = a[7:5]; hf = a[1];
    w1 = l1_lookup(s1, t1);
    if (w1 >= 0) begin
      r.read_data = l1_word[s1][w1][a[0]];
      r.served_from = tlch_pkg::SRC_L1;
    end else begin
      w2 = l2_lookup(s2, t2);
      if (w2 >= 0) begin
        r.served_from = tlch_pkg::SRC_L2;
      end else begin
        w2 = l2_load(s2, t2);
        r.served_from = tlch_pkg::SRC_RAM;
      end
      r.read_data = l2_word[s2][w2][a[1:0]];
      w1 = pick_victim(l1_vld[s1][0], l1_vld[s1][1], l1_ord[s1][0], l1_ord[s1][1]);
      l1_vld[s1][w1] = 1'b1;
      l1_ord[s1][w1] = 1'b0;
      l1_tag[s1][w1] = t1;
      l1_ord[s1][w1 ^ 1] = ~l1_ord[s1][w1 ^ 1];
      for (int k = 0; k < 2; k++) l1_word[s1][w1][k] = l2_word[s2][w2][{hf, k[0]}];
    end
    // write: update l1 then copy its line into the l2 half and mark dirty
    if (tr.kind == tlch_pkg::KIND_WRITE) begin
      w1 = l1_lookup(s1, t1);
      l1_word[s1][w1][a[0]] = tr.write_data;
      w2 = l2_lookup(s2, t2);
      if (w2 < 0) w2 = l2_load(s2, t2);
      for (int k = 0; k < 2; k++) l2_word[s2][w2][{hf, k[0]}] = l1_word[s1][w1][k];
      l2_dty[s2][w2] = 1'b1;
    end
    return r;
  endfunction

  // predict on accepted input, compare on accepted output
  always @(posedge clk) begin
    tlch_pkg::out_item_t exp_r;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
      pending_count <= 0;
      expected_reads.delete();
      for (int s = 0; s < 4; s++)
        for (int w = 0; w < 2; w++) begin
          l1_vld[s][w] = 0; l1_ord[s][w] = 0; l1_tag[s][w] = 0;
          l1_word[s][w][0] = 0; l1_word[s][w][1] = 0;
        end
      for (int s = 0; s < 8; s++)
        for (int w = 0; w < 2; w++) begin
          l2_vld[s][w] = 0; l2_ord[s][w] = 0; l2_dty[s][w] = 0; l2_tag[s][w] = 0;
          for (int k = 0; k < 4; k++) l2_word[s][w][k] = 0;
        end
      for (int i = 0; i < 256; i++) ram[i] = 0;
    end else begin
      if (in_valid && !in_stall) expected_reads.push_back(access_cache(in_data));
      if (out_valid && !out_stall) begin
        if (expected_reads.size() == 0) begin
          $error("unexpected result transaction %h", out_data);
          errs++;
        end else begin
          exp_r = expected_reads.pop_front();
          if (out_data.read_data !== exp_r.read_data) begin
            $error("read_data expected %h actual %h", exp_r.read_data, out_data.read_data);
            errs++;
          end
          if (out_data.served_from !== exp_r.served_from) begin
            $error("served_from expected %0d actual %0d",
                   exp_r.served_from, out_data.served_from);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending_count <= expected_reads.size();
    end
  end
endmodule

[tb/tb_two_level_cache_hierarchy_core.sv]
module tb_two_level_cache_hierarchy_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  tlch_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tlch_pkg::out_item_t out_data;
  int        fail_count;
  int        pending_count;
  int        cycle_count = 0;
  bit        hold_off = 1'b0;
  bit        stall_freely = 1'b1;

  two_level_cache_hierarchy_core dut (.*);

  tb_two_level_cache_hierarchy_checker checker_i (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stall pattern, with long hold-offs on request
  initial begin
    int mode;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        out_stall <= 1'b0;
        hold_off = 1'b0;
      end else begin
        mode = (cycle_count / 500) % 3;
        if (!stall_freely || mode == 0) out_stall <= 1'b0;
        else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= ($urandom_range(0, 1) == 0);
      end
    end
  end

  // offer one transaction and hold it until accepted
  task automatic send_access(logic kind, logic [7:0] addr, logic [31:0] wd);
    in_valid <= 1'b1;
    in_data <= '{kind: kind, word_addr: addr, write_data: wd};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_gap();
    int g;
    g = $urandom_range(1, 4);
    in_valid <= 1'b0;
    repeat (g) @(posedge clk);
  endtask

  // addresses mostly confined to l2 sets 0 and 1 to force conflicts and evictions
  function automatic logic [7:0] pick_addr();
    logic [7:0] a;
    a = 8'($urandom);
    if ($urandom_range(0, 3) != 0) a[4:2] = 3'($urandom_range(0, 1));
    return a;
  endfunction

  initial begin
    int burst;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, both kinds, dirty eviction and l2 miss on write
    send_access(1'b0, 8'h00, 32'h0);
    send_access(1'b1, 8'h00, 32'hFFFF_FFFF);
    send_access(1'b0, 8'h00, 32'h0);
    send_access(1'b1, 8'hFF, 32'hA5A5_5A5A);
    send_access(1'b0, 8'hFF, 32'h0);
    send_access(1'b1, 8'h01, 32'h5A5A_A5A5);
    send_access(1'b1, 8'h01, 32'h1234_5678);
    // same l2 set, three tags: the dirty block at 0 is not evicted
    send_access(1'b0, 8'h20, 32'h0);
    send_access(1'b0, 8'h40, 32'h0);
    send_access(1'b0, 8'h01, 32'h0);
    // l2 set 2 is churned around a write to 0x08; the load of 0x68 evicts its dirty block
    send_access(1'b0, 8'h08, 32'h0);
    send_access(1'b0, 8'h28, 32'h0);
    send_access(1'b0, 8'h48, 32'h0);
    send_access(1'b1, 8'h08, 32'hDEAD_BEEF);
    send_access(1'b0, 8'h68, 32'h0);
    send_access(1'b0, 8'h88, 32'h0);
    send_access(1'b0, 8'h08, 32'h0);
    send_access(1'b0, 8'hAA, 32'h0);

    // random bursts
    for (int n = 0; n < 600; ) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++, n++)
        send_access(1'($urandom_range(0, 1)), pick_addr(), $urandom);
      if (n % 150 < burst) hold_off = 1'b1;
      if (n % 200 < burst) begin
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
        @(posedge clk);
      end
      if ($urandom_range(0, 1)) idle_gap();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    wait (pending_count == 0);
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
